// ===== rtl/core/pll_pkg.sv =====
// ----------------------------------------------------------------------------
// pll_pkg
// Shared types and constants of the pooled linked list engine: operation and
// status codes, controller states and the command/status bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package pll_pkg;

  localparam int POOL_DEPTH_DEF = 16;
  localparam int SCAN_W = 16;
  localparam logic [31:0] FREED_VALUE = 32'hFFFF_FFFF;
  localparam logic [31:0] HEAD_VALUE = 32'h0000_0000;

  typedef enum logic {
    FUNC_APPEND = 1'b0,
    FUNC_DELETE = 1'b1
  } func_t;

  typedef enum logic [2:0] {
    ST_APPENDED  = 3'd0,
    ST_DELETED   = 3'd1,
    ST_FULL      = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_HEAD_ONLY = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_APP_NODE,
    S_APP_LINK,
    S_WALK,
    S_DEL,
    S_DONE
  } state_t;

  typedef struct packed {
    logic load_item;
    logic scan_step;
    logic set_full;
    logic app_node;
    logic app_link;
    logic walk_step;
    logic del_commit;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic scan_hit;
    logic scan_last;
    logic walk_done;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/pll_ifs.sv =====
// ----------------------------------------------------------------------------
// pll_ifs
// Handshake channels of the engine: request items in, response items out.
// ----------------------------------------------------------------------------
`default_nettype none

interface pll_req_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [31:0] value;

  modport source (output valid, output func, output value, input ready);
  modport sink (input valid, input func, input value, output ready);
endinterface

interface pll_rsp_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [3:0] slot;
  logic [4:0] list_length;

  modport source (output valid, output status, output slot, output list_length,
                  input ready);
  modport sink (input valid, input status, input slot, input list_length,
                output ready);
endinterface

`default_nettype wire

// ===== rtl/core/pll_ctrl.sv =====
// ----------------------------------------------------------------------------
// pll_ctrl
// Sequencer of the engine: steps the datapath through free-slot scan and
// tail link for an append, list walk and unlink for a delete.
// ----------------------------------------------------------------------------
`default_nettype none

module pll_ctrl (
  input  wire           clk,
  input  wire           rst,
  input  wire           req_valid,
  input  wire           req_func,
  output logic          req_ready,
  input  pll_pkg::sts_t sts,
  output pll_pkg::cmd_t cmd
);

  pll_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pll_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    req_ready = 1'b0;
    case (state)
      pll_pkg::S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load_item = 1'b1;
          state_next = (req_func == pll_pkg::FUNC_DELETE) ? pll_pkg::S_WALK
                                                          : pll_pkg::S_SCAN;
        end
      end
      pll_pkg::S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_hit) begin
          state_next = pll_pkg::S_APP_NODE;
        end else if (sts.scan_last) begin
          cmd.set_full = 1'b1;
          state_next = pll_pkg::S_DONE;
        end
      end
      pll_pkg::S_APP_NODE: begin
        cmd.app_node = 1'b1;
        state_next = pll_pkg::S_APP_LINK;
      end
      pll_pkg::S_APP_LINK: begin
        cmd.app_link = 1'b1;
        state_next = pll_pkg::S_DONE;
      end
      pll_pkg::S_WALK: begin
        cmd.walk_step = 1'b1;
        if (sts.walk_done) begin
          state_next = pll_pkg::S_DEL;
        end
      end
      pll_pkg::S_DEL: begin
        cmd.del_commit = 1'b1;
        state_next = pll_pkg::S_DONE;
      end
      pll_pkg::S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next = pll_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = pll_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/pll_datapath.sv =====
// ----------------------------------------------------------------------------
// pll_datapath
// Slot pool storage, used marks, head/tail registers, walk and scan logic and
// the output register of the engine.
// ----------------------------------------------------------------------------
`default_nettype none

module pll_datapath #(
  parameter int POOL_DEPTH = pll_pkg::POOL_DEPTH_DEF
) (
  input  wire           clk,
  input  wire           rst,
  input  pll_pkg::cmd_t cmd,
  output pll_pkg::sts_t sts,
  input  wire  [31:0]   item_value,
  input  wire           rsp_ready,
  output logic          rsp_valid,
  output logic [2:0]    rsp_status,
  output logic [3:0]    rsp_slot,
  output logic [4:0]    rsp_length
);

  localparam int IDX_W = $clog2(POOL_DEPTH);
  localparam int LINK_W = $clog2(POOL_DEPTH + 1);
  localparam int CNT_W = LINK_W;
  localparam int NUM_GRP = (POOL_DEPTH + pll_pkg::SCAN_W - 1) / pll_pkg::SCAN_W;
  localparam int GRP_W = (NUM_GRP > 1) ? $clog2(NUM_GRP) : 1;
  localparam int SCAN_LEN = NUM_GRP * pll_pkg::SCAN_W;
  localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(POOL_DEPTH);

  // storage; entries are only meaningful while their used mark is set
  logic [31:0]       value_mem [POOL_DEPTH];
  logic [LINK_W-1:0] link_mem  [POOL_DEPTH];
  logic [31:0]       rd_value;
  logic [LINK_W-1:0] rd_link;
  logic [IDX_W-1:0]  rd_addr;

  logic              lk_wr_en;
  logic [IDX_W-1:0]  lk_wr_addr;
  logic [LINK_W-1:0] lk_wr_data;

  logic [POOL_DEPTH-1:0] used;
  logic [LINK_W-1:0]     head_link;
  logic [IDX_W-1:0]      tail;
  logic [CNT_W-1:0]      count;

  logic [31:0]           value_r;
  logic [GRP_W-1:0]      grp;
  logic [IDX_W-1:0]      fresh;

  logic [IDX_W-1:0]      cur;
  logic [IDX_W-1:0]      steps;
  logic [IDX_W-1:0]      prev;
  logic                  prev_valid;
  logic                  matched;
  logic [IDX_W-1:0]      pred;
  logic                  pred_valid;
  logic [IDX_W-1:0]      victim;
  logic [LINK_W-1:0]     victim_link;

  logic [2:0]            res_status;
  logic [3:0]            res_slot;

  logic [SCAN_LEN-1:0]       used_pad;
  logic [pll_pkg::SCAN_W-1:0] grp_bits;
  logic                      hit;
  logic [IDX_W-1:0]          hit_idx;

  logic [31:0]       node_value;
  logic [LINK_W-1:0] node_link;
  logic              node_end;

  // free-slot scan over one group of used marks
  always_comb begin
    used_pad = '1;
    used_pad[POOL_DEPTH-1:0] = used;
    grp_bits = used_pad[grp*pll_pkg::SCAN_W +: pll_pkg::SCAN_W];
    hit = 1'b0;
    hit_idx = '0;
    for (int j = pll_pkg::SCAN_W - 1; j >= 0; j--) begin
      if (!grp_bits[j]) begin
        hit = 1'b1;
        hit_idx = IDX_W'(int'(grp) * pll_pkg::SCAN_W + j);
      end
    end
  end

  // node under the walk pointer: head from registers, used slots from memory, freed slots as a marker
  always_comb begin
    if (cur == '0) begin
      node_value = pll_pkg::HEAD_VALUE;
      node_link = head_link;
    end else if (used[cur]) begin
      node_value = rd_value;
      node_link = rd_link;
    end else begin
      node_value = pll_pkg::FREED_VALUE;
      node_link = NULL_LINK;
    end
    node_end = (node_link >= NULL_LINK);
    rd_addr = node_link[IDX_W-1:0];
  end

  assign sts.scan_hit = hit;
  assign sts.scan_last = (grp == GRP_W'(NUM_GRP - 1));
  assign sts.walk_done = node_end || (steps == IDX_W'(POOL_DEPTH - 1));
  assign sts.out_free = !rsp_valid || rsp_ready;

  // link memory write port
  always_comb begin
    lk_wr_en = 1'b0;
    lk_wr_addr = fresh;
    lk_wr_data = NULL_LINK;
    if (cmd.app_node) begin
      lk_wr_en = 1'b1;
    end else if (cmd.app_link && tail != '0) begin
      lk_wr_en = 1'b1;
      lk_wr_addr = tail;
      lk_wr_data = LINK_W'(fresh);
    end else if (cmd.del_commit && matched && pred_valid && pred != '0) begin
      lk_wr_en = 1'b1;
      lk_wr_addr = pred;
      lk_wr_data = victim_link;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.app_node) begin
      value_mem[fresh] <= value_r;
    end
    if (lk_wr_en) begin
      link_mem[lk_wr_addr] <= lk_wr_data;
    end
    rd_value <= value_mem[rd_addr];
    rd_link <= link_mem[rd_addr];
  end

  // list control state
  always_ff @(posedge clk) begin
    if (rst) begin
      used <= POOL_DEPTH'(1);
      head_link <= NULL_LINK;
      tail <= '0;
      count <= CNT_W'(1);
    end else begin
      if (cmd.app_node) begin
        used[fresh] <= 1'b1;
      end
      if (cmd.app_link) begin
        if (tail == '0) begin
          head_link <= LINK_W'(fresh);
        end
        tail <= fresh;
        count <= count + CNT_W'(1);
      end
      if (cmd.del_commit && matched && pred_valid) begin
        if (pred == '0) begin
          head_link <= victim_link;
        end
        used[victim] <= 1'b0;
        if (tail == victim) begin
          tail <= pred;
        end
        if (count != '0) begin
          count <= count - CNT_W'(1);
        end
      end
    end
  end

  // per-item working registers
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      value_r <= item_value;
      grp <= '0;
      cur <= '0;
      steps <= '0;
      prev <= '0;
      prev_valid <= 1'b0;
      matched <= 1'b0;
      pred_valid <= 1'b0;
    end
    if (cmd.scan_step) begin
      if (hit) begin
        fresh <= hit_idx;
      end else if (!sts.scan_last) begin
        grp <= grp + GRP_W'(1);
      end
    end
    if (cmd.walk_step) begin
      if (node_value == value_r) begin
        matched <= 1'b1;
        pred <= prev;
        pred_valid <= prev_valid;
        victim <= cur;
        victim_link <= node_link;
      end
      prev <= cur;
      prev_valid <= 1'b1;
      cur <= node_link[IDX_W-1:0];
      steps <= steps + IDX_W'(1);
    end
    if (cmd.set_full) begin
      res_status <= pll_pkg::ST_FULL;
      res_slot <= '0;
    end
    if (cmd.app_link) begin
      res_status <= pll_pkg::ST_APPENDED;
      res_slot <= 4'(fresh);
    end
    if (cmd.del_commit) begin
      if (!matched) begin
        res_status <= pll_pkg::ST_NOT_FOUND;
        res_slot <= '0;
      end else if (!pred_valid) begin
        res_status <= pll_pkg::ST_HEAD_ONLY;
        res_slot <= '0;
      end else begin
        res_status <= pll_pkg::ST_DELETED;
        res_slot <= 4'(victim);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.out_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      rsp_status <= res_status;
      rsp_slot <= res_slot;
      rsp_length <= 5'(count);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/pooled_linked_list_engine.sv =====
// ----------------------------------------------------------------------------
// pooled_linked_list_engine
// Singly linked list in a fixed pool of slots with a permanent head node.
// ----------------------------------------------------------------------------
// An append runs the free-slot scan of 16 used marks per cycle, the node write and
// the tail link; a delete runs the walk, which reads one linked slot per cycle
// from the pool memory, and then the unlink. Items are taken one at a time; the
// next is taken when the sequencer is back in idle after the result is loaded.
// Reset (synchronous, active high) leaves only the head; no clearing.
`default_nettype none

module pooled_linked_list_engine #(
  parameter int POOL_DEPTH = pll_pkg::POOL_DEPTH_DEF
) (
  input wire     clk,
  input wire     rst,
  pll_req_if.sink   request,
  pll_rsp_if.source response
);

  // command and status bundle between sequencer and datapath
  pll_pkg::cmd_t cmd;
  pll_pkg::sts_t sts;

  // sequencer: holds the request channel while an item is in work
  pll_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (request.valid),
    .req_func  (request.func),
    .req_ready (request.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath: pool memories, used marks, walk/scan logic, output register
  pll_datapath #(
    .POOL_DEPTH (POOL_DEPTH)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .item_value (request.value),
    .rsp_ready  (response.ready),
    .rsp_valid  (response.valid),
    .rsp_status (response.status),
    .rsp_slot   (response.slot),
    .rsp_length (response.list_length)
  );

endmodule

`default_nettype wire
